// ===== rtl/core/edre_pkg.sv =====
// Shared types and codes for the edit distance row engine.
// No dependencies; used by edit_distance_row_engine.
package edre_pkg;

   localparam int KIND_W = 2;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_LOAD    = 2'd0;
   localparam kind_type KIND_PROCESS = 2'd1;
   localparam kind_type KIND_REPORT  = 2'd2;

   localparam int SYM_W  = 8;
   localparam int DIST_W = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DELIVER
   } state_type;

endpackage

// ===== rtl/core/edre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instanced for the reference bytes and the row costs.
module edre_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/edit_distance_row_engine.sv =====
// Levenshtein edit distance engine, single-row dynamic programming table in RAM.
// Depends on edre_pkg and edre_ram.
//
// Usage:
//   req channel: tuser[1:0] is the kind, tdata[7:0] the symbol byte.
//     Kind 0 appends one reference byte before the first kind 1. Kind 1 takes
//     one byte of the other string and sweeps the row, one cell per cycle:
//     the sweep holds the input (req_tready low) until every column of the
//     row cost RAM is read and written back. Kind 2 reads the last row
//     entry and returns one transaction on rsp; kind 3 is dropped.
//   rsp channel: tdata[6:0] distance (saturated at 127), tuser[0] overflow.
//     The result sits in an output register; kinds 0 and 1 keep flowing while
//     it waits. A kind 2 stays in the deliver state until the output register
//     is free, so a stalled receiver eventually stalls req as well.
//   Report: a kind 2 reads the row RAM on acceptance, then the deliver
//     state loads the output register once it is free.
//   Reset: synchronous, active high; clears lengths, row counter, overflow
//     and the output valid flag. No RAM clearing pass: every row entry is
//     written on load before it is read, and entry zero lives in a counter.
//   Overflow: bytes beyond MAX_LEN on either string set a sticky flag that
//     is reported and cleared with the next kind 2.
module edit_distance_row_engine #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] distance, [7] zero
   output logic [0:0] rsp_tuser    // [0] overflow
);

   localparam int LW = $clog2(MAX_LEN + 1);       // counters, 0..MAX_LEN
   localparam int AW = $clog2(MAX_LEN);           // RAM address
   localparam int CW = LW;                        // row cost, 0..MAX_LEN
   localparam int DW = (CW > edre_pkg::DIST_W) ? CW : edre_pkg::DIST_W;

   edre_pkg::state_type state_ff, state_in;

   logic [LW-1:0] len_ff, len_in;       // reference length
   logic [LW-1:0] rows_ff, rows_in;     // rows processed, also row entry zero
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] iss_ff, iss_in;       // next sweep column to read
   logic          pv_ff, pv_in;         // read data of a sweep column pending
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] left_ff, left_in;
   logic [7:0]    sym_ff, sym_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [edre_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_accept;
   edre_pkg::kind_type kind;
   logic          sweep_rd;
   logic          out_free;
   logic          len_full;
   logic          rows_full;

   logic          ref_we;
   logic [AW-1:0] ref_waddr;
   logic [7:0]    ref_rdata;
   logic          row_we;
   logic [AW-1:0] row_waddr;
   logic [CW-1:0] row_wdata;
   logic          row_re;
   logic [AW-1:0] row_raddr;
   logic [CW-1:0] row_rdata;

   logic [CW-1:0] min_ud;
   logic [CW-1:0] min_all;
   logic [CW-1:0] new_cost;
   logic [CW-1:0] final_cost;
   logic [DW-1:0] final_wide;

   assign kind       = req_tuser;
   assign req_tready = (state_ff == edre_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign sweep_rd   = (state_ff == edre_pkg::ST_SWEEP) && (iss_ff < len_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign len_full   = (len_ff == LW'(MAX_LEN));
   assign rows_full  = (rows_ff == LW'(MAX_LEN));

   // One cell of the recurrence: match takes the diagonal, else min of three plus one.
   assign min_ud   = (row_rdata < diag_ff) ? row_rdata : diag_ff;
   assign min_all  = (min_ud < left_ff) ? min_ud : left_ff;
   assign new_cost = (ref_rdata == sym_ff) ? diag_ff : CW'({1'b0, min_all} + (CW+1)'(1));

   // Empty reference: the answer is row entry zero, i.e. the row counter.
   assign final_cost = (len_ff == '0) ? rows_ff : row_rdata;
   assign final_wide = DW'(final_cost);

   // RAM ports: loads write in idle, the sweep writes one column behind its reads.
   assign ref_we    = req_accept && (kind == edre_pkg::KIND_LOAD) && (rows_ff == '0) && !len_full;
   assign ref_waddr = len_ff[AW-1:0];
   assign row_we    = ref_we || pv_ff;
   assign row_waddr = pv_ff ? paddr_ff : len_ff[AW-1:0];
   assign row_wdata = pv_ff ? new_cost : CW'(len_ff + LW'(1));
   assign row_re    = sweep_rd || (req_accept && (kind == edre_pkg::KIND_REPORT));
   assign row_raddr = sweep_rd ? iss_ff[AW-1:0] : AW'(LW'(len_ff - LW'(1)));

   edre_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (req_tdata),
      .rd_en   (sweep_rd),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (ref_rdata)
   );

   // Row entries one..MAX_LEN, stored at address minus one.
   edre_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LEN)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         edre_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (kind == edre_pkg::KIND_PROCESS && !rows_full && len_ff != '0) begin
                  state_in = edre_pkg::ST_SWEEP;
               end else if (kind == edre_pkg::KIND_REPORT) begin
                  state_in = edre_pkg::ST_DELIVER;
               end
            end
         end
         edre_pkg::ST_SWEEP: begin
            // Leave once all columns are read; the last write-back retires this cycle.
            if (!sweep_rd) begin
               state_in = edre_pkg::ST_IDLE;
            end
         end
         edre_pkg::ST_DELIVER: begin
            if (out_free) begin
               state_in = edre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edre_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      len_in       = len_ff;
      rows_in      = rows_ff;
      ovf_in       = ovf_ff;
      iss_in       = iss_ff;
      pv_in        = sweep_rd;
      paddr_in     = iss_ff[AW-1:0];
      diag_in      = diag_ff;
      left_in      = left_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         edre_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (kind)
                  edre_pkg::KIND_LOAD: begin
                     if (rows_ff == '0) begin
                        if (len_full) begin
                           ovf_in = 1'b1;
                        end else begin
                           len_in = LW'(len_ff + LW'(1));
                        end
                     end
                  end
                  edre_pkg::KIND_PROCESS: begin
                     if (rows_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        diag_in = rows_ff;
                        left_in = CW'(rows_ff + LW'(1));
                        rows_in = LW'(rows_ff + LW'(1));
                        sym_in  = req_tdata;
                        iss_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         edre_pkg::ST_SWEEP: begin
            if (sweep_rd) begin
               iss_in = LW'(iss_ff + LW'(1));
            end
            if (pv_ff) begin
               diag_in = row_rdata;
               left_in = new_cost;
            end
         end
         edre_pkg::ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = (final_wide > DW'(127)) ? 7'd127 : final_wide[6:0];
               rsp_ovf_in   = ovf_ff;
               len_in       = '0;
               rows_in      = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edre_pkg::ST_IDLE;
         len_ff       <= '0;
         rows_ff      <= '0;
         ovf_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rows_ff      <= rows_in;
         ovf_ff       <= ovf_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff      <= iss_in;
      paddr_ff    <= paddr_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      sym_ff      <= sym_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff};
   assign rsp_tuser  = rsp_ovf_ff;

   // A pending write-back only exists inside a sweep.
   a_pending_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (state_ff == edre_pkg::ST_SWEEP))
      else $error("sweep write-back outside sweep");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LW'(MAX_LEN)) && (rows_ff <= LW'(MAX_LEN)))
      else $error("length counter beyond MAX_LEN");

   // Reference bytes after the first processed byte must not grow the row.
   a_late_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && kind == edre_pkg::KIND_LOAD && rows_ff != '0) |=> $stable(len_ff))
      else $error("late reference byte changed length");

   a_wb_addr: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (LW'(paddr_ff) < len_ff))
      else $error("sweep writes beyond reference length");

   // Delivery fills the output register and clears the strings.
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == edre_pkg::ST_DELIVER && out_free) |=>
         (rsp_valid_ff && len_ff == '0 && rows_ff == '0 && !ovf_ff))
      else $error("report did not deliver and clear");

endmodule
